// ===== design/xfv_pkg.sv =====
// ----------------------------------------------------------------------------
// xfv_pkg
// Shared constants and types for the XOR frame validator.
// ----------------------------------------------------------------------------
package xfv_pkg;

    localparam logic [7:0] HDR0_BYTE  = 8'hAA;
    localparam logic [7:0] HDR1_BYTE  = 8'h55;
    localparam logic [7:0] TAIL0_BYTE = 8'h55;
    localparam logic [7:0] TAIL1_BYTE = 8'hAA;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_HEADER = 2'd1;
    localparam logic [1:0] STATUS_TAIL   = 2'd2;
    localparam logic [1:0] STATUS_PARITY = 2'd3;

    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       frame_start;
    } xfv_byte_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] check_status;
        logic [7:0] body_length;
    } xfv_result_t;

endpackage

// ===== design/xfv_in_reg.sv =====
// ----------------------------------------------------------------------------
// xfv_in_reg
// Input register that holds one received byte until the checker takes it.
// ----------------------------------------------------------------------------
module xfv_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_data_byte,
    input  logic              s_frame_start,
    input  logic              advance,
    output xfv_pkg::xfv_byte_t byte_q
);
    import xfv_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       start_reg;

    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg  <= s_data_byte;
            start_reg <= s_frame_start;
        end
    end

    assign byte_q.valid       = valid_reg;
    assign byte_q.data_byte   = data_reg;
    assign byte_q.frame_start = start_reg;

endmodule

// ===== design/xfv_frame_chk.sv =====
// ----------------------------------------------------------------------------
// xfv_frame_chk
// Frame state and per-byte checks: header, length, parity and tail.
// ----------------------------------------------------------------------------
module xfv_frame_chk (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  xfv_pkg::xfv_byte_t  byte_q,
    output xfv_pkg::xfv_result_t result
);
    import xfv_pkg::*;

    logic [8:0] pos_reg;
    logic [8:0] pos_next;
    logic [7:0] len_reg;
    logic [7:0] len_next;
    logic [7:0] parity_reg;
    logic [7:0] parity_next;
    logic       parity_good_reg;
    logic       parity_good_next;
    logic       tail_good_reg;
    logic       tail_good_next;
    logic       active_reg;
    logic       active_next;

    logic [8:0] pos_cur;
    logic [7:0] len_cur;
    logic [7:0] parity_cur;
    logic       parity_good_cur;
    logic       tail_good_cur;
    logic       active_cur;
    logic [8:0] len_ext;
    logic       tail_ok;
    logic [7:0] b;

    always_comb begin
        b = byte_q.data_byte;
        if (byte_q.frame_start) begin
            pos_cur         = '0;
            len_cur         = '0;
            parity_cur      = '0;
            parity_good_cur = 1'b0;
            tail_good_cur   = 1'b0;
            active_cur      = 1'b1;
        end else begin
            pos_cur         = pos_reg;
            len_cur         = len_reg;
            parity_cur      = parity_reg;
            parity_good_cur = parity_good_reg;
            tail_good_cur   = tail_good_reg;
            active_cur      = active_reg;
        end
        len_ext = {1'b0, len_cur};

        pos_next         = pos_cur;
        len_next         = len_cur;
        parity_next      = parity_cur;
        parity_good_next = parity_good_cur;
        tail_good_next   = tail_good_cur;
        active_next      = active_cur;
        tail_ok          = 1'b0;

        result.valid        = 1'b0;
        result.check_status = STATUS_OK;
        result.body_length  = '0;

        if (active_cur) begin
            pos_next = pos_cur + 9'd1;
            if (pos_cur == 9'd0 || pos_cur == 9'd1) begin
                if (b != ((pos_cur == 9'd0) ? HDR0_BYTE : HDR1_BYTE)) begin
                    result.valid        = 1'b1;
                    result.check_status = STATUS_HEADER;
                    active_next         = 1'b0;
                    pos_next            = pos_cur;
                end
            end else if (pos_cur == 9'd2) begin
                len_next    = b;
                parity_next = b;
            end else if (pos_cur < len_ext + 9'd3) begin
                parity_next = parity_cur ^ b;
            end else if (pos_cur == len_ext + 9'd3) begin
                parity_good_next = (parity_cur == b);
            end else if (pos_cur == len_ext + 9'd4) begin
                tail_good_next = (b == TAIL0_BYTE);
            end else begin
                tail_ok        = tail_good_cur && (b == TAIL1_BYTE);
                tail_good_next = tail_ok;
                result.valid   = 1'b1;
                if (!tail_ok) begin
                    result.check_status = STATUS_TAIL;
                end else if (!parity_good_cur) begin
                    result.check_status = STATUS_PARITY;
                end else begin
                    result.check_status = STATUS_OK;
                end
                result.body_length = len_cur;
                active_next        = 1'b0;
                pos_next           = pos_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= '0;
            len_reg         <= '0;
            parity_reg      <= '0;
            parity_good_reg <= 1'b0;
            tail_good_reg   <= 1'b0;
            active_reg      <= 1'b0;
        end else if (advance) begin
            pos_reg         <= pos_next;
            len_reg         <= len_next;
            parity_reg      <= parity_next;
            parity_good_reg <= parity_good_next;
            tail_good_reg   <= tail_good_next;
            active_reg      <= active_next;
        end
    end

    // A reported frame leaves the checker idle.
    a_idle_after_report: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && result.valid) |=> !active_reg)
        else $error("checker still active after a report");

    // A header failure never carries a length.
    a_header_no_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (result.valid && result.check_status == STATUS_HEADER) |-> (result.body_length == 8'd0))
        else $error("header error with nonzero length");

    // The position never runs past the final tail byte.
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (pos_reg <= {1'b0, len_reg} + 9'd5))
        else $error("byte position beyond frame end");

endmodule

// ===== design/xfv_out_reg.sv =====
// ----------------------------------------------------------------------------
// xfv_out_reg
// Result register that holds one report until the result transfer completes.
// ----------------------------------------------------------------------------
module xfv_out_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  xfv_pkg::xfv_result_t result,
    output logic                 out_free,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_check_status,
    output logic [7:0]           m_body_length
);
    import xfv_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [1:0] status_reg;
    logic [7:0] length_reg;
    logic       load;

    assign out_free = !valid_reg || m_ready;
    assign load     = advance && result.valid;

    always_comb begin
        valid_next = valid_reg;
        if (out_free) begin
            valid_next = load;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            status_reg <= result.check_status;
            length_reg <= result.body_length;
        end
    end

    assign m_valid        = valid_reg;
    assign m_check_status = status_reg;
    assign m_body_length  = length_reg;

endmodule

// ===== design/xor_frame_validator_core.sv =====
// The report for an accepted byte is loaded into the result register behind m_valid.
// Throughput: one byte per cycle; the frame state update is a single registered pass.
// A waiting result stalls input only while the result register stays full.
// Reset: synchronous, active low; clears valids and frame state, block goes idle.
// ----------------------------------------------------------------------------
// xor_frame_validator_core
// Checks header, length, XOR parity and tail of frames received byte by byte.
// ----------------------------------------------------------------------------
module xor_frame_validator_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_frame_start,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_check_status,
    output logic [7:0] m_body_length
);
    import xfv_pkg::*;

    xfv_byte_t   byte_q;
    xfv_result_t result;
    logic        out_free;
    logic        advance;

    assign advance = byte_q.valid && out_free;

    xfv_in_reg u_in_reg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_frame_start (s_frame_start),
        .advance       (advance),
        .byte_q        (byte_q)
    );

    xfv_frame_chk u_frame_chk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .byte_q  (byte_q),
        .result  (result)
    );

    xfv_out_reg u_out_reg (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .result         (result),
        .out_free       (out_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_check_status (m_check_status),
        .m_body_length  (m_body_length)
    );

endmodule
